// File: src/plane_aabb_bounds_defines.svh
// ----------------------------------------------------------------------------
// plane_aabb_bounds_defines
// Assertion macros shared by the checker of the plane bounding box block.
// ----------------------------------------------------------------------------
`ifndef PLANE_AABB_BOUNDS_DEFINES_SVH
`define PLANE_AABB_BOUNDS_DEFINES_SVH

// Check a property on every rising clock edge outside reset
`define PAB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Check a property on every cycle that shows a result
`define PAB_ASSERT_DONE(lbl, prop, msg) \
  `PAB_ASSERT(lbl, done |-> (prop), msg)

`endif

// File: src/pab_pkg.sv
// ----------------------------------------------------------------------------
// pab_pkg
// Shared types, register indexes and width helpers of the plane bounding box.
// ----------------------------------------------------------------------------
package pab_pkg;

  // Default fraction bits of the quaternion components
  localparam int QUAT_FRAC_BITS_DEF = 14;

  // Configuration register file
  localparam int CFG_AW = 1;
  localparam logic [CFG_AW-1:0] REG_SCALE_X = 1'b0;
  localparam logic [CFG_AW-1:0] REG_SCALE_Z = 1'b1;
  localparam logic signed [31:0] SCALE_RESET = 32'sd65536;

  // Three Q16.16 coordinates travel together
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec3_t;

  // Width of a matrix entry at twice the quaternion fraction bits
  function automatic int ent_w(input int f);
    return (2 * f + 2 > 35) ? 2 * f + 2 : 35;
  endfunction

  // Width of a matrix entry rounded to the quaternion fraction bits
  function automatic int mat_w(input int f);
    return ent_w(f) - f;
  endfunction

  // Width of a scaled entry rounded to 16 fraction bits
  function automatic int ext_w(input int f);
    return mat_w(f) + 32 - f;
  endfunction

endpackage

// File: src/pab_rot.sv
// ----------------------------------------------------------------------------
// pab_rot
// Quaternion to rotation matrix: two stages, products then rounded entries.
// ----------------------------------------------------------------------------
module pab_rot #(
  parameter int QUAT_FRAC_BITS = pab_pkg::QUAT_FRAC_BITS_DEF,
  localparam int MW = pab_pkg::mat_w(QUAT_FRAC_BITS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [15:0]   quat_w,
  input  logic signed [15:0]   quat_x,
  input  logic signed [15:0]   quat_y,
  input  logic signed [15:0]   quat_z,
  input  pab_pkg::vec3_t       in_pos,
  output logic                 out_valid,
  output logic signed [MW-1:0] col_x [3],
  output logic signed [MW-1:0] col_z [3],
  output pab_pkg::vec3_t       out_pos
);

  localparam int F  = QUAT_FRAC_BITS;
  localparam int EW = pab_pkg::ent_w(QUAT_FRAC_BITS);
  localparam logic signed [EW-1:0] ONE  = EW'(1) <<< (2 * F);
  localparam logic signed [EW-1:0] HALF = EW'(1) <<< (F - 1);

  logic                 v1;
  pab_pkg::vec3_t       pos1;
  logic signed [31:0]   p_xx, p_yy, p_zz, p_xy, p_xz, p_yz, p_wx, p_wy, p_wz;
  logic signed [EW-1:0] e_x [3];
  logic signed [EW-1:0] e_z [3];

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  // Stage 1: form the component products
  always_ff @(posedge clk) begin
    p_xx <= quat_x * quat_x;
    p_yy <= quat_y * quat_y;
    p_zz <= quat_z * quat_z;
    p_xy <= quat_x * quat_y;
    p_xz <= quat_x * quat_z;
    p_yz <= quat_y * quat_z;
    p_wx <= quat_w * quat_x;
    p_wy <= quat_w * quat_y;
    p_wz <= quat_w * quat_z;
    pos1 <= in_pos;
  end

  // Build the local x and z columns, rounding half folded in
  always_comb begin
    e_x[0] = ONE + HALF - ((EW'(p_yy) + EW'(p_zz)) <<< 1);
    e_x[1] = ((EW'(p_xy) + EW'(p_wz)) <<< 1) + HALF;
    e_x[2] = ((EW'(p_xz) - EW'(p_wy)) <<< 1) + HALF;
    e_z[0] = ((EW'(p_xz) + EW'(p_wy)) <<< 1) + HALF;
    e_z[1] = ((EW'(p_yz) - EW'(p_wx)) <<< 1) + HALF;
    e_z[2] = ONE + HALF - ((EW'(p_xx) + EW'(p_yy)) <<< 1);
  end

  // Stage 2: drop the low fraction bits (floor after adding half)
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      col_x[i] <= e_x[i][EW-1:F];
      col_z[i] <= e_z[i][EW-1:F];
    end
    out_pos <= pos1;
  end

endmodule

// File: src/pab_ext.sv
// ----------------------------------------------------------------------------
// pab_ext
// Scale the matrix columns and sum magnitudes into per-axis half extents.
// ----------------------------------------------------------------------------
module pab_ext #(
  parameter int QUAT_FRAC_BITS = pab_pkg::QUAT_FRAC_BITS_DEF,
  localparam int MW = pab_pkg::mat_w(QUAT_FRAC_BITS),
  localparam int AW = pab_pkg::ext_w(QUAT_FRAC_BITS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [MW-1:0] col_x [3],
  input  logic signed [MW-1:0] col_z [3],
  input  pab_pkg::vec3_t       in_pos,
  input  logic signed [31:0]   scale_x,
  input  logic signed [31:0]   scale_z,
  output logic                 out_valid,
  output logic        [AW:0]   half_ext [3],
  output pab_pkg::vec3_t       out_pos
);

  localparam int F  = QUAT_FRAC_BITS;
  localparam int PW = MW + 32;
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (F - 1);

  logic                 v3, v4;
  pab_pkg::vec3_t       pos3, pos4;
  logic signed [PW-1:0] prod_x [3];
  logic signed [PW-1:0] prod_z [3];
  logic signed [PW-1:0] rnd_x  [3];
  logic signed [PW-1:0] rnd_z  [3];
  logic signed [AW:0]   a_x    [3];
  logic signed [AW:0]   a_z    [3];
  logic        [AW-1:0] mag_x  [3];
  logic        [AW-1:0] mag_z  [3];
  logic        [AW-1:0] abs_x  [3];
  logic        [AW-1:0] abs_z  [3];

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v3        <= in_valid;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  // Stage 3: scale each column entry
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      prod_x[i] <= PW'(col_x[i]) * PW'(scale_x);
      prod_z[i] <= PW'(col_z[i]) * PW'(scale_z);
    end
    pos3 <= in_pos;
  end

  // Round to 16 fraction bits and take the magnitude
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd_x[i] = prod_x[i] + HALF;
      rnd_z[i] = prod_z[i] + HALF;
      a_x[i]   = {rnd_x[i][PW-1], rnd_x[i][PW-1:F]};
      a_z[i]   = {rnd_z[i][PW-1], rnd_z[i][PW-1:F]};
      abs_x[i] = a_x[i][AW] ? AW'(-a_x[i]) : AW'(a_x[i]);
      abs_z[i] = a_z[i][AW] ? AW'(-a_z[i]) : AW'(a_z[i]);
    end
  end

  // Stage 4: hold the magnitudes
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      mag_x[i] <= abs_x[i];
      mag_z[i] <= abs_z[i];
    end
    pos4 <= pos3;
  end

  // Stage 5: sum both contributions per axis
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      half_ext[i] <= (AW + 1)'(mag_x[i]) + (AW + 1)'(mag_z[i]);
    end
    out_pos <= pos4;
  end

endmodule

// File: src/pab_box.sv
// ----------------------------------------------------------------------------
// pab_box
// Final stage: offset the position by the half extents and saturate.
// ----------------------------------------------------------------------------
module pab_box #(
  parameter int QUAT_FRAC_BITS = pab_pkg::QUAT_FRAC_BITS_DEF,
  localparam int AW = pab_pkg::ext_w(QUAT_FRAC_BITS)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic  [AW:0]   half_ext [3],
  input  pab_pkg::vec3_t in_pos,
  output logic           done,
  output pab_pkg::vec3_t box_lo,
  output pab_pkg::vec3_t box_hi
);

  localparam int RW = AW + 3;
  localparam logic signed [RW-1:0] SAT_HI = RW'($signed(32'h7fff_ffff));
  localparam logic signed [RW-1:0] SAT_LO = RW'($signed(32'h8000_0000));

  logic signed [RW-1:0] pos_w [3];
  logic signed [RW-1:0] h_w   [3];
  logic signed [RW-1:0] lo_w  [3];
  logic signed [RW-1:0] hi_w  [3];
  logic        [31:0]   lo_s  [3];
  logic        [31:0]   hi_s  [3];

  // Clamp a wide result into the Q16.16 range
  function automatic logic [31:0] sat32(input logic signed [RW-1:0] v);
    logic [31:0] r;
    priority if (v > SAT_HI) r = SAT_HI[31:0];
    else if (v < SAT_LO)     r = SAT_LO[31:0];
    else                     r = v[31:0];
    return r;
  endfunction

  // Offset and saturate each axis
  always_comb begin
    pos_w[0] = RW'(in_pos.x);
    pos_w[1] = RW'(in_pos.y);
    pos_w[2] = RW'(in_pos.z);
    for (int i = 0; i < 3; i++) begin
      h_w[i]  = RW'($signed({1'b0, half_ext[i]}));
      lo_w[i] = pos_w[i] - h_w[i];
      hi_w[i] = pos_w[i] + h_w[i];
      lo_s[i] = sat32(lo_w[i]);
      hi_s[i] = sat32(hi_w[i]);
    end
  end

  // Advance the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  // Stage 6: register the box
  always_ff @(posedge clk) begin
    box_lo.x <= lo_s[0];
    box_lo.y <= lo_s[1];
    box_lo.z <= lo_s[2];
    box_hi.x <= hi_s[0];
    box_hi.y <= hi_s[1];
    box_hi.z <= hi_s[2];
  end

endmodule

// File: src/plane_aabb_bounds.sv
// Throughput: one transaction per cycle; busy stays low after reset.
// Six register stages: products, matrix entries, scale multiplies,
// magnitudes, axis sums, saturated box; done marks each result for one cycle.
// Reset clears the stage valid bits, holds busy high and sets both scales to 1.0.
// ----------------------------------------------------------------------------
// plane_aabb_bounds
// Axis-aligned bounding box of a scaled, rotated plane from a pose stream.
// ----------------------------------------------------------------------------
module plane_aabb_bounds #(
  parameter int QUAT_FRAC_BITS = pab_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [15:0]          quat_w,
  input  logic signed [15:0]          quat_x,
  input  logic signed [15:0]          quat_y,
  input  logic signed [15:0]          quat_z,
  input  logic signed [31:0]          pos_x,
  input  logic signed [31:0]          pos_y,
  input  logic signed [31:0]          pos_z,
  input  logic                        cfg_we,
  input  logic [pab_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [31:0]                 cfg_wdata,
  output logic                        done,
  output logic signed [31:0]          min_x,
  output logic signed [31:0]          min_y,
  output logic signed [31:0]          min_z,
  output logic signed [31:0]          max_x,
  output logic signed [31:0]          max_y,
  output logic signed [31:0]          max_z
);

  localparam int MW = pab_pkg::mat_w(QUAT_FRAC_BITS);
  localparam int AW = pab_pkg::ext_w(QUAT_FRAC_BITS);

  logic signed [31:0]   scale_x_q;
  logic signed [31:0]   scale_z_q;
  logic                 in_valid;
  pab_pkg::vec3_t       in_pos;
  logic                 rot_valid;
  logic signed [MW-1:0] col_x [3];
  logic signed [MW-1:0] col_z [3];
  pab_pkg::vec3_t       rot_pos;
  logic                 ext_valid;
  logic        [AW:0]   half_ext [3];
  pab_pkg::vec3_t       ext_pos;
  pab_pkg::vec3_t       box_lo;
  pab_pkg::vec3_t       box_hi;

  // Hold busy high through reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // Write the scale registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_x_q <= pab_pkg::SCALE_RESET;
      scale_z_q <= pab_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pab_pkg::REG_SCALE_X: scale_x_q <= cfg_wdata;
        pab_pkg::REG_SCALE_Z: scale_z_q <= cfg_wdata;
      endcase
    end
  end

  // Accept a transaction
  assign in_valid  = start && !busy;
  assign in_pos.x  = pos_x;
  assign in_pos.y  = pos_y;
  assign in_pos.z  = pos_z;

  pab_rot #(
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_rot (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .quat_w    (quat_w),
    .quat_x    (quat_x),
    .quat_y    (quat_y),
    .quat_z    (quat_z),
    .in_pos    (in_pos),
    .out_valid (rot_valid),
    .col_x     (col_x),
    .col_z     (col_z),
    .out_pos   (rot_pos)
  );

  pab_ext #(
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_ext (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rot_valid),
    .col_x     (col_x),
    .col_z     (col_z),
    .in_pos    (rot_pos),
    .scale_x   (scale_x_q),
    .scale_z   (scale_z_q),
    .out_valid (ext_valid),
    .half_ext  (half_ext),
    .out_pos   (ext_pos)
  );

  pab_box #(
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_box (
    .clk      (clk),
    .rst      (rst),
    .in_valid (ext_valid),
    .half_ext (half_ext),
    .in_pos   (ext_pos),
    .done     (done),
    .box_lo   (box_lo),
    .box_hi   (box_hi)
  );

  // Drive the result ports
  assign min_x = box_lo.x;
  assign min_y = box_lo.y;
  assign min_z = box_lo.z;
  assign max_x = box_hi.x;
  assign max_y = box_hi.y;
  assign max_z = box_hi.z;

endmodule

// File: src/pab_chk.sv
// ----------------------------------------------------------------------------
// pab_chk
// Port-level checks of the plane bounding box block, bound to the top level.
// ----------------------------------------------------------------------------
`include "plane_aabb_bounds_defines.svh"

module pab_chk (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic signed [31:0]         pos_x,
  input logic                       done,
  input logic signed [31:0]         min_x,
  input logic signed [31:0]         min_y,
  input logic signed [31:0]         min_z,
  input logic signed [31:0]         max_x,
  input logic signed [31:0]         max_y,
  input logic signed [31:0]         max_z
);

  logic accept;
  logic box_ordered;

  // Summarize the handshake and the box shape
  assign accept      = start && !busy;
  assign box_ordered = (min_x <= max_x) && (min_y <= max_y) && (min_z <= max_z);

  `PAB_ASSERT(a_latency, accept |-> ##6 done, "accepted transaction gave no result")
  `PAB_ASSERT_DONE(a_no_spurious, $past(accept, 6), "result without a transaction")
  `PAB_ASSERT_DONE(a_box_order, box_ordered, "lower bound above upper bound")
  `PAB_ASSERT_DONE(a_pos_in_x, min_x <= $past(pos_x, 6) && $past(pos_x, 6) <= max_x, "pos_x")

endmodule

bind plane_aabb_bounds pab_chk u_pab_chk (.*);

// File: tb/tb_plane_aabb_bounds.sv
// ----------------------------------------------------------------------------
// tb_plane_aabb_bounds
// Self-checking bench for the plane bounding box block. Poses are sent
// through the start/busy command port, and each box is checked against a
// bit-exact predictor of the rotated, scaled unit square. Scale registers
// are rewritten between phases while the pipeline is empty, and the sender
// idles at several rates.
// ----------------------------------------------------------------------------
module tb_plane_aabb_bounds;

  localparam int QFB        = pab_pkg::QUAT_FRAC_BITS_DEF;
  localparam int WDOG_LIMIT = 2000;
  localparam int DRAIN_WAIT = 12;
  localparam int N_PHASES   = 7;
  localparam int PHASE_LEN  = 133;

  typedef struct {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } pose_t;

  typedef struct {
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] min_z;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
    logic signed [31:0] max_z;
  } box_t;

  // Predict boxes from poses and compare them with what the block returns
  class box_scoreboard;
    longint      scale_x;
    longint      scale_z;
    box_t        expected_boxes[$];
    int unsigned error_count;
    int unsigned box_count;

    function new();
      scale_x     = pab_pkg::SCALE_RESET;
      scale_z     = pab_pkg::SCALE_RESET;
      error_count = 0;
      box_count   = 0;
    endfunction

    // Round half up while dropping n fraction bits
    function longint round_frac(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function logic signed [31:0] clamp32(longint v);
      if (v > longint'(32'sh7FFFFFFF))
        return 32'sh7FFFFFFF;
      if (v < -longint'(64'sh80000000))
        return 32'sh80000000;
      return v[31:0];
    endfunction

    // Half-extent along one world axis from the two column entries
    function longint axis_reach(longint ex, longint ez);
      longint mx, mz, ax, az;
      mx = round_frac(ex, QFB);
      mz = round_frac(ez, QFB);
      ax = round_frac(mx * scale_x, QFB);
      az = round_frac(mz * scale_z, QFB);
      if (ax < 0) ax = -ax;
      if (az < 0) az = -az;
      return ax + az;
    endfunction

    function void note_pose(pose_t p);
      longint w, x, y, z, one, rx, ry, rz;
      box_t   b;
      w   = p.quat_w;
      x   = p.quat_x;
      y   = p.quat_y;
      z   = p.quat_z;
      one = longint'(1) << (2 * QFB);
      rx  = axis_reach(one - 2 * (y * y + z * z), 2 * (x * z + w * y));
      ry  = axis_reach(2 * (x * y + w * z), 2 * (y * z - w * x));
      rz  = axis_reach(2 * (x * z - w * y), one - 2 * (x * x + y * y));
      b.min_x = clamp32(longint'(p.pos_x) - rx);
      b.min_y = clamp32(longint'(p.pos_y) - ry);
      b.min_z = clamp32(longint'(p.pos_z) - rz);
      b.max_x = clamp32(longint'(p.pos_x) + rx);
      b.max_y = clamp32(longint'(p.pos_y) + ry);
      b.max_z = clamp32(longint'(p.pos_z) + rz);
      expected_boxes.push_back(b);
    endfunction

    function void check_field(string fname, logic signed [31:0] e, logic signed [31:0] a);
      if (e !== a) begin
        $error("%s: expected %0d, got %0d", fname, e, a);
        error_count++;
      end
    endfunction

    function void check_box(box_t got);
      box_t e;
      if (expected_boxes.size() == 0) begin
        $error("box with no pose pending: min (%0d %0d %0d) max (%0d %0d %0d)",
               got.min_x, got.min_y, got.min_z, got.max_x, got.max_y, got.max_z);
        error_count++;
        return;
      end
      e = expected_boxes.pop_front();
      box_count++;
      check_field("min_x", e.min_x, got.min_x);
      check_field("min_y", e.min_y, got.min_y);
      check_field("min_z", e.min_z, got.min_z);
      check_field("max_x", e.max_x, got.max_x);
      check_field("max_y", e.max_y, got.max_y);
      check_field("max_z", e.max_z, got.max_z);
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic signed [15:0]         quat_w, quat_x, quat_y, quat_z;
  logic signed [31:0]         pos_x, pos_y, pos_z;
  logic                       cfg_we;
  logic [pab_pkg::CFG_AW-1:0] cfg_addr;
  logic [31:0]                cfg_wdata;
  logic                       done;
  logic signed [31:0]         min_x, min_y, min_z, max_x, max_y, max_z;

  box_scoreboard sb;
  int unsigned   pose_count;
  int unsigned   quiet_cycles;
  int unsigned   setting_count;

  plane_aabb_bounds dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .quat_w    (quat_w),
    .quat_x    (quat_x),
    .quat_y    (quat_y),
    .quat_z    (quat_z),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .done      (done),
    .min_x     (min_x),
    .min_y     (min_y),
    .min_z     (min_z),
    .max_x     (max_x),
    .max_y     (max_y),
    .max_z     (max_z)
  );

  always #10 clk = ~clk;

  // Record accepted poses, check strobed boxes, and guard against a hang
  always @(posedge clk) begin
    pose_t p;
    box_t  b;
    if (!rst) begin
      if (start && !busy) begin
        p = '{quat_w, quat_x, quat_y, quat_z, pos_x, pos_y, pos_z};
        sb.note_pose(p);
        pose_count++;
      end
      if (done) begin
        b = '{min_x, min_y, min_z, max_x, max_y, max_z};
        sb.check_box(b);
      end
      if ((start && !busy) || done)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Present one pose after an idle gap and hold it until accepted
  task automatic send_pose(input pose_t p, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start  <= 1'b1;
    quat_w <= p.quat_w;
    quat_x <= p.quat_x;
    quat_y <= p.quat_y;
    quat_z <= p.quat_z;
    pos_x  <= p.pos_x;
    pos_y  <= p.pos_y;
    pos_z  <= p.pos_z;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop start and hold until every pending box has come back
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.expected_boxes.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Write both scale registers back to back on an idle pipeline
  task automatic set_scales(input logic signed [31:0] sx, input logic signed [31:0] sz);
    cfg_we    <= 1'b1;
    cfg_addr  <= pab_pkg::REG_SCALE_X;
    cfg_wdata <= sx;
    @(negedge clk);
    cfg_addr  <= pab_pkg::REG_SCALE_Z;
    cfg_wdata <= sz;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.scale_x = sx;
    sb.scale_z = sz;
    setting_count++;
  endtask

  function automatic logic signed [15:0] rand_quat();
    logic signed [15:0] edges[5] = '{16'sh8000, -16'sd16384, 16'sd0, 16'sd16384, 16'sh7FFF};
    case ($urandom_range(9))
      0:       return edges[$urandom_range(4)];
      1, 2:    return 16'($urandom);
      default: return 16'($urandom_range(32768) - 16384);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_pos();
    logic signed [31:0] edges[3] = '{32'sh80000000, 32'sd0, 32'sh7FFFFFFF};
    case ($urandom_range(7))
      0:       return edges[$urandom_range(2)];
      1, 2:    return $urandom_range(32'h0020_0000) - 32'sh0010_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic int idle_gap(int pct);
    int g;
    g = 0;
    while ($urandom_range(99) < pct && g < 20) g++;
    return g;
  endfunction

  initial begin
    pose_t              directed[$];
    pose_t              p;
    logic signed [31:0] sx[N_PHASES];
    logic signed [31:0] sz[N_PHASES];
    int                 pct;

    sb            = new();
    pose_count    = 0;
    quiet_cycles  = 0;
    setting_count = 0;
    clk       = 1'b0;
    rst       = 1'b1;
    start     = 1'b0;
    quat_w    = '0;
    quat_x    = '0;
    quat_y    = '0;
    quat_z    = '0;
    pos_x     = '0;
    pos_y     = '0;
    pos_z     = '0;
    cfg_we    = 1'b0;
    cfg_addr  = pab_pkg::REG_SCALE_X;
    cfg_wdata = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed poses at the reset scales: identity, quarter turns about each
    // axis, pure axis quaternions, zero and non-unit quaternions, components
    // past the unit range, and positions at the edges to force saturation
    directed = '{
      '{16384, 0, 0, 0, 0, 0, 0},
      '{11585, 11585, 0, 0, 32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000},
      '{11585, 0, 11585, 0, 0, 0, 0},
      '{11585, 0, 0, 11585, 0, 0, 0},
      '{0, 16384, 0, 0, 0, 0, 0},
      '{0, 0, 16384, 0, 0, 0, 0},
      '{0, 0, 0, 16384, 0, 0, 0},
      '{-16384, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0},
      '{8192, 8192, 8192, 8192, 12345, -12345, 1},
      '{16384, 16384, 16384, 16384, 0, 0, 0},
      '{-16384, -16384, -16384, -16384, 0, 0, 0},
      '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0, 0, 0},
      '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0, 0, 0},
      '{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 0, 0, 0},
      '{16384, 0, 0, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF},
      '{16384, 0, 0, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000},
      '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 32'sh7FFFFFFF, 32'sh80000000, 0},
      '{1, -1, 1, -1, -1, 1, -1},
      '{14189, 4096, -4096, 6000, 32'sh7FFF_0000, -32'sh7FFF_0000, 32'sh0000_8000}
    };
    foreach (directed[i]) send_pose(directed[i], 0);
    settle();

    // Scale settings per phase: both signs at full range, zero, mixed,
    // and random words so every register bit toggles
    sx = '{32'sd65536, 32'sh7FFFFFFF, 32'sd0, -32'sd65536, $urandom,
           $urandom_range(32'h0004_0000) - 32'sh0002_0000, 32'sh80000000};
    sz = '{32'sd65536, 32'sh80000000, 32'sd0, 32'sd196608, $urandom,
           $urandom_range(32'h0004_0000) - 32'sh0002_0000, 32'sh7FFFFFFF};

    for (int ph = 0; ph < N_PHASES; ph++) begin
      set_scales(sx[ph], sz[ph]);
      case (ph % 3)
        0:       pct = 0;
        1:       pct = 56;
        default: pct = 15;
      endcase
      for (int n = 0; n < PHASE_LEN; n++) begin
        p = '{rand_quat(), rand_quat(), rand_quat(), rand_quat(),
              rand_pos(), rand_pos(), rand_pos()};
        // Now and then let the pipeline run dry before the next pose
        if ($urandom_range(99) == 0)
          settle();
        send_pose(p, idle_gap(pct));
      end
      settle();
    end

    repeat (DRAIN_WAIT) @(posedge clk);

    if (sb.expected_boxes.size() != 0) begin
      $error("%0d boxes never arrived", sb.expected_boxes.size());
      sb.error_count++;
    end
    $display("Sent %0d poses over %0d scale settings; %0d boxes compared.",
             pose_count, setting_count, sb.box_count);
    $display("Covered rotations, non-unit quaternions, edge positions and scale extremes.");
    if (sb.error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
